@@ design/dstc_pkg.sv @@
// shared constants and functions for the dst rule time zone converter
package dstc_pkg;
  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned SecsDay = 86400;
  localparam int unsigned SecsYear = 31536000;
  localparam int unsigned SecsLeapYear = 31622400;
  localparam int unsigned EpochYear = 1970;
  // weekday index of 1 jan 1970, counted as (days + 4) % 7
  localparam logic [2:0] EpochWday = 3'd4;

  localparam logic [1:0] RegDstRule = 2'd0;
  localparam logic [1:0] RegStdRule = 2'd1;
  localparam logic [1:0] RegDstOff  = 2'd2;
  localparam logic [1:0] RegStdOff  = 2'd3;

  localparam logic [14:0] DstRuleReset = 15'd6178;
  localparam logic [14:0] StdRuleReset = 15'd20515;
  localparam logic [10:0] DstOffReset  = 11'd120;
  localparam logic [10:0] StdOffReset  = 11'd60;

  // cumulative days before month m (1..12), non-leap year
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] r;
    r = 9'd0;
    case (m)
      4'd1: r = 9'd0;
      4'd2: r = 9'd31;
      4'd3: r = 9'd59;
      4'd4: r = 9'd90;
      4'd5: r = 9'd120;
      4'd6: r = 9'd151;
      4'd7: r = 9'd181;
      4'd8: r = 9'd212;
      4'd9: r = 9'd243;
      4'd10: r = 9'd273;
      4'd11: r = 9'd304;
      4'd12: r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // month_base(m) modulo 7
  function automatic logic [2:0] month_wd(input logic [3:0] m);
    logic [2:0] r;
    r = 3'd0;
    case (m)
      4'd1: r = 3'd0;
      4'd2: r = 3'd3;
      4'd3: r = 3'd3;
      4'd4: r = 3'd6;
      4'd5: r = 3'd1;
      4'd6: r = 3'd4;
      4'd7: r = 3'd6;
      4'd8: r = 3'd2;
      4'd9: r = 3'd5;
      4'd10: r = 3'd0;
      4'd11: r = 3'd3;
      4'd12: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // century by reciprocal multiplication, exact for 12-bit years
  function automatic logic is_leap(input logic [11:0] y);
    logic [6:0] c;
    c = 7'((25'(y) * 25'd5243) >> 19);
    return (y[1:0] == 2'b00) && ((y != 12'(c) * 12'd100) || (c[1:0] == 2'b00));
  endfunction
endpackage

@@ design/dstc_if.sv @@
// valid/ready channel interfaces for items, results and configuration
interface dstc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] time_in;
  modport source (output valid, mode, time_in, input ready);
  modport sink (input valid, mode, time_in, output ready);
endinterface

interface dstc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_out;
  logic        is_dst;
  modport source (output valid, time_out, is_dst, input ready);
  modport sink (input valid, time_out, is_dst, output ready);
endinterface

interface dstc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/dstc_year_unit.sv @@
// iterative year-of-time and days-to-year unit, one year per cycle
module dstc_year_unit #(
  parameter int unsigned TimeBits = dstc_pkg::TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                find_i,      // 1: find year of secs_i, 0: days before year_i
  input  logic [TimeBits-1:0] secs_i,
  input  logic [11:0]         year_i,
  output logic                done_o,
  output logic [11:0]         year_o,
  output logic [TimeBits-1:0] base_o,      // days from epoch to 1 Jan of year_o
  output logic [2:0]          wday_o       // (base_o + 4) % 7
);
  logic                busy_q, busy_d, find_q, find_d;
  logic [TimeBits-1:0] rem_q, rem_d, base_q, base_d;
  logic [11:0]         y_q, y_d, tgt_q, tgt_d;
  logic [2:0]          wd_q, wd_d;
  logic                leap;
  logic [8:0]          ylen;
  logic [TimeBits-1:0] ysecs;
  logic [3:0]          wsum;

  assign leap  = dstc_pkg::is_leap(y_q);
  assign ylen  = leap ? 9'd366 : 9'd365;
  assign ysecs = leap ? TimeBits'(dstc_pkg::SecsLeapYear) : TimeBits'(dstc_pkg::SecsYear);
  // a year moves the weekday on by its length modulo 7
  assign wsum  = 4'(wd_q) + (leap ? 4'd2 : 4'd1);

  always_comb begin
    busy_d = busy_q;
    find_d = find_q;
    rem_d  = rem_q;
    base_d = base_q;
    y_d    = y_q;
    tgt_d  = tgt_q;
    wd_d   = wd_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      find_d = find_i;
      rem_d  = secs_i;
      tgt_d  = year_i;
      base_d = '0;
      y_d    = 12'(dstc_pkg::EpochYear);
      wd_d   = dstc_pkg::EpochWday;
    end else if (busy_q) begin
      if (find_q ? (rem_q < ysecs) : (y_q >= tgt_q)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        rem_d  = rem_q - ysecs;
        base_d = base_q + TimeBits'(ylen);
        y_d    = y_q + 12'd1;
        wd_d   = (wsum >= 4'd7) ? 3'(wsum - 4'd7) : 3'(wsum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    find_q <= find_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    y_q    <= y_d;
    tgt_q  <= tgt_d;
    wd_q   <= wd_d;
  end

  assign year_o = y_q;
  assign base_o = base_q;
  assign wday_o = wd_q;
endmodule

@@ design/dst_rule_time_zone_converter.sv @@
// top level of the dst rule time zone converter
// use: send a word on in_if (mode, time_in); one word comes back on out_if
// with the converted time and the daylight saving flag.
// config words on cfg_if set the two rules and two offsets (index 0..3);
// a write made while idle forces a recompute of the cached start instants.
// timing: the year of the item is found by a shared year unit that steps
// one year per cycle by subtracting year lengths in seconds.
// on a year change or after a config write, each rule takes another pass
// of the year unit, which runs one year further for a last week of december.
// one item is taken at a time: in_if.ready is high only in idle with the
// output register empty, so the next word can go in the cycle after the
// result is taken.
// the result sits in an output register until out_if.ready takes it;
// the block waits there while the receiver stalls.
// reset clears the cache valid flag and loads the default rules
// (last sunday of march 02:00, last sunday of october 03:00, +120/+60 min).
module dst_rule_time_zone_converter #(
  parameter int unsigned TimeBits = dstc_pkg::TimeBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dstc_in_if.sink     in_if,
  dstc_out_if.source  out_if,
  dstc_cfg_if.sink    cfg_if
);
  typedef enum logic [3:0] {
    S_IDLE, S_YEAR, S_WAIT_YEAR, S_CHECK, S_RULE, S_RULE_YEAR, S_RULE_DAY,
    S_RULE_DOW, S_RULE_FIN, S_UTC, S_DECIDE, S_OUT
  } state_e;

  state_e state_q;
  logic [14:0] dst_rule_q, std_rule_q;
  logic [10:0] dst_off_q, std_off_q;
  logic        valid_q;
  logic [11:0] cyear_q;
  logic [TimeBits-1:0] dst_loc_q, std_loc_q, dst_utc_q, std_utc_q;
  logic        mode_q;
  logic [31:0] tin_q;
  logic [11:0] year_q;
  logic        which_q;              // 0: dst rule, 1: std rule
  logic [TimeBits-1:0] t_q;          // rule instant being built
  logic [TimeBits-1:0] tdays_q;      // its day number
  logic [2:0]  wd_q;                 // (day of t_q + 4) % 7
  logic [3:0]  mon_q;
  logic [2:0]  week_q;
  logic        last_q;
  logic        dst_q;
  logic [31:0] tout_q;
  logic        ovalid_q;

  // year unit
  logic                yu_start, yu_find, yu_done;
  logic [TimeBits-1:0] yu_secs, yu_base;
  logic [11:0]         yu_year_in, yu_year;
  logic [2:0]          yu_wd;

  dstc_year_unit #(.TimeBits(TimeBits)) u_year (
    .clk_i, .rst_ni,
    .start_i(yu_start), .find_i(yu_find), .secs_i(yu_secs), .year_i(yu_year_in),
    .done_o(yu_done), .year_o(yu_year), .base_o(yu_base), .wday_o(yu_wd)
  );

  logic cfg_fire, in_fire;
  assign cfg_if.ready = 1'b1;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;
  assign in_if.ready = (state_q == S_IDLE) && !ovalid_q;
  assign in_fire = in_if.valid && in_if.ready;
  assign out_if.valid = ovalid_q;
  assign out_if.time_out = tout_q;
  assign out_if.is_dst = dst_q;

  // current rule fields
  logic [14:0] rule;
  logic [4:0]  r_hour;
  logic [2:0]  r_dow, r_week;
  logic [3:0]  r_mon, mon_cl;
  assign rule   = which_q ? std_rule_q : dst_rule_q;
  assign r_hour = rule[4:0];
  assign r_dow  = rule[7:5];
  assign r_week = rule[10:8];
  assign r_mon  = rule[14:11];
  assign mon_cl = (r_mon == 4'd0) ? 4'd1 : ((r_mon > 4'd12) ? 4'd12 : r_mon);

  // offset in seconds, sign extended
  function automatic logic [TimeBits-1:0] off_secs(input logic [10:0] m);
    return TimeBits'($signed({{(TimeBits-11){m[10]}}, m}) * $signed(TimeBits'(60)));
  endfunction

  // weekday of the first day of the month, plus a day when the hour runs past 23
  logic [TimeBits-1:0] hrs_secs;
  logic                leap_adj;
  logic [3:0]          wsum;
  logic [2:0]          wd_fold;
  logic [2:0]          delta;
  assign hrs_secs = TimeBits'(r_hour) * TimeBits'(3600);
  assign leap_adj = (mon_q > 4'd2) && dstc_pkg::is_leap(yu_year);
  assign wsum = 4'(yu_wd) + 4'(dstc_pkg::month_wd(mon_q)) + 4'(leap_adj)
                + 4'(r_hour >= 5'd24);
  assign wd_fold = (wsum >= 4'd14) ? 3'(wsum - 4'd14)
                 : ((wsum >= 4'd7) ? 3'(wsum - 4'd7) : 3'(wsum));
  // (dow + 7 - (wd+1)) % 7
  logic [3:0] dtmp;
  assign dtmp = 4'(r_dow) + 4'd6 - 4'(wd_q);
  assign delta = (dtmp >= 4'd7) ? 3'(dtmp - 4'd7) : 3'(dtmp);

  function automatic logic in_dst(input logic [TimeBits-1:0] t,
                                  input logic [TimeBits-1:0] ds,
                                  input logic [TimeBits-1:0] ss);
    if (ss > ds) return (t >= ds) && (t < ss);
    return !((t >= ss) && (t < ds));
  endfunction

  logic dst_now;
  assign dst_now = mode_q ? in_dst(TimeBits'(tin_q), dst_loc_q, std_loc_q)
                          : in_dst(TimeBits'(tin_q), dst_utc_q, std_utc_q);

  always_comb begin
    yu_start   = 1'b0;
    yu_find    = 1'b1;
    yu_secs    = TimeBits'(tin_q);
    yu_year_in = year_q;
    if (state_q == S_YEAR) yu_start = 1'b1;
    if (state_q == S_RULE) begin
      yu_start = 1'b1;
      yu_find  = 1'b0;
      yu_year_in = (r_week == 3'd0 && mon_cl == 4'd12) ? year_q + 12'd1 : year_q;
    end
  end

  logic [3:0] mon_n;
  assign mon_n = (r_week == 3'd0) ? ((mon_cl == 4'd12) ? 4'd1 : mon_cl + 4'd1) : mon_cl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      dst_rule_q <= dstc_pkg::DstRuleReset;
      std_rule_q <= dstc_pkg::StdRuleReset;
      dst_off_q  <= dstc_pkg::DstOffReset;
      std_off_q  <= dstc_pkg::StdOffReset;
      valid_q    <= 1'b0;
      ovalid_q   <= 1'b0;
      cyear_q    <= '0;
    end else begin
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      if (cfg_fire) begin
        valid_q <= 1'b0;
        unique case (cfg_if.index)
          dstc_pkg::RegDstRule: dst_rule_q <= cfg_if.data[14:0];
          dstc_pkg::RegStdRule: std_rule_q <= cfg_if.data[14:0];
          dstc_pkg::RegDstOff:  dst_off_q  <= cfg_if.data[10:0];
          dstc_pkg::RegStdOff:  std_off_q  <= cfg_if.data[10:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: if (in_fire) begin
          mode_q  <= in_if.mode;
          tin_q   <= in_if.time_in;
          state_q <= S_YEAR;
        end
        S_YEAR: state_q <= S_WAIT_YEAR;
        S_WAIT_YEAR: if (yu_done) begin
          year_q  <= yu_year;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          which_q <= 1'b0;
          state_q <= (valid_q && cyear_q == year_q) ? S_DECIDE : S_RULE;
        end
        S_RULE: begin
          mon_q   <= mon_n;
          last_q  <= (r_week == 3'd0);
          week_q  <= (r_week == 3'd0) ? 3'd1 : r_week;
          state_q <= S_RULE_YEAR;
        end
        S_RULE_YEAR: if (yu_done) begin
          tdays_q <= yu_base + TimeBits'(dstc_pkg::month_base(mon_q)) + TimeBits'(leap_adj);
          wd_q    <= wd_fold;
          state_q <= S_RULE_DAY;
        end
        S_RULE_DAY: begin
          t_q     <= tdays_q * TimeBits'(dstc_pkg::SecsDay) + hrs_secs;
          state_q <= S_RULE_DOW;
        end
        S_RULE_DOW: begin
          t_q <= t_q + (TimeBits'(7) * TimeBits'(week_q - 3'd1) + TimeBits'(delta))
                       * TimeBits'(dstc_pkg::SecsDay);
          state_q <= S_RULE_FIN;
        end
        S_RULE_FIN: begin
          if (!which_q) begin
            dst_loc_q <= last_q ? t_q - TimeBits'(7 * dstc_pkg::SecsDay) : t_q;
            which_q   <= 1'b1;
            state_q   <= S_RULE;
          end else begin
            std_loc_q <= last_q ? t_q - TimeBits'(7 * dstc_pkg::SecsDay) : t_q;
            state_q   <= S_UTC;
          end
        end
        S_UTC: begin
          dst_utc_q <= dst_loc_q - off_secs(std_off_q);
          std_utc_q <= std_loc_q - off_secs(dst_off_q);
          cyear_q   <= year_q;
          valid_q   <= 1'b1;
          state_q   <= S_DECIDE;
        end
        S_DECIDE: begin
          dst_q   <= dst_now;
          tout_q  <= mode_q
            ? tin_q - 32'(off_secs(dst_now ? dst_off_q : std_off_q))
            : tin_q + 32'(off_secs(dst_now ? dst_off_q : std_off_q));
          state_q <= S_OUT;
        end
        S_OUT: begin
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_if.ready) else $error("ready while busy");
  a_out_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_OUT)) else $error("result without decide");
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && state_q == S_IDLE) |=> !valid_q) else $error("cache not cleared");
endmodule
